// File: sv/assert_macros.svh
// Assertion macros used by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication or plain property, checked at each rising edge out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");

// Condition that must never hold out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: %m");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: sv/psd_pkg.sv
package psd_pkg;

    // Width of the signed distance result field
    localparam int OUT_BITS = 34;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FEW  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        IT_MUL  = 2'd0,
        IT_DIV  = 2'd1,
        IT_SQRT = 2'd2
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_PREV,
        ST_LD_PREV,
        ST_RD_CUR,
        ST_LD_CUR,
        ST_MUL,
        ST_SQ,
        ST_DIV,
        ST_ROOT,
        ST_NEXT,
        ST_OUT
    } psd_state_t;

endpackage

// File: sv/psd_iter.sv
module psd_iter #(
    parameter int S = 67
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  psd_pkg::iter_req_t    req,
    input  logic [2*S-1:0]        opa,
    input  logic [S-1:0]          opb,
    output logic                  done,
    output logic [2*S-1:0]        result
);
    import psd_pkg::*;

    localparam int PW   = 2 * S;
    localparam int RW   = S + 3;
    localparam int CNTW = $clog2(PW + 1);

    logic            busy_reg;
    logic            done_reg;
    iter_op_t        op_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   sh_reg;
    logic [S-1:0]    b_reg;
    logic [RW-1:0]   rem_reg;
    logic [CNTW-1:0] cnt_reg;

    logic [S:0]      div_sh;
    logic [S:0]      div_dif;
    logic            div_ge;
    logic [RW-1:0]   sq_sh;
    logic [RW-1:0]   sq_trial;
    logic [RW-1:0]   sq_dif;
    logic            sq_ge;
    logic            last_step;

    // Restoring divide step: shift in one numerator bit, subtract if it fits
    assign div_sh  = {rem_reg[S-1:0], sh_reg[PW-1]};
    assign div_ge  = div_sh >= {1'b0, b_reg};
    assign div_dif = div_sh - {1'b0, b_reg};

    // Digit-by-digit root step: bring down two bits, try 4*root+1
    assign sq_sh    = {rem_reg[RW-3:0], sh_reg[PW-1 -: 2]};
    assign sq_trial = {1'b0, acc_reg[S-1:0], 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_dif   = sq_sh - sq_trial;

    assign last_step = (cnt_reg == CNTW'(1));

    // Control: busy flag and one-cycle done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                unique case (op_reg)
                    IT_MUL: begin
                        if (b_reg == '0) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    IT_DIV, IT_SQRT: begin
                        if (last_step) begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default: begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Datapath: load operands, then one bit or one digit per cycle
    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg  <= req.op;
            acc_reg <= '0;
            sh_reg  <= opa;
            b_reg   <= opb;
            rem_reg <= '0;
            cnt_reg <= (req.op == IT_DIV) ? CNTW'(PW) : CNTW'(S);
        end else if (busy_reg) begin
            unique case (op_reg)
                IT_MUL: begin
                    if (b_reg[0]) begin
                        acc_reg <= acc_reg + sh_reg;
                    end
                    sh_reg <= {sh_reg[PW-2:0], 1'b0};
                    b_reg  <= {1'b0, b_reg[S-1:1]};
                end
                IT_DIV: begin
                    sh_reg  <= {sh_reg[PW-2:0], 1'b0};
                    rem_reg <= RW'(div_ge ? div_dif : div_sh);
                    acc_reg <= {acc_reg[PW-2:0], div_ge};
                    cnt_reg <= cnt_reg - CNTW'(1);
                end
                IT_SQRT: begin
                    sh_reg  <= {sh_reg[PW-3:0], 2'b00};
                    rem_reg <= sq_ge ? sq_dif : sq_sh;
                    acc_reg <= {acc_reg[PW-2:0], sq_ge};
                    cnt_reg <= cnt_reg - CNTW'(1);
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

// File: sv/polygon_signed_distance.sv
// Polygon vertex store with signed-distance point queries.
// Input stream s_*: one request per item; opcode clears the store, appends a
// vertex, or queries a point (coordinates signed Q16.16). Output stream m_*:
// exactly one result per request, in request order.
// Clear, append and short queries are answered straight into the output
// register when accepted. A full query walks every stored edge through one
// shared iterative unit (shift-add multiply, restoring divide, digit-serial
// square root). Each edge needs a memory read and six or eight products,
// plus for a perpendicular foot a square and a divide, and for every edge
// a root.
// The block takes one request at a time: s_tready is low during a query.
// A single output register holds the result; while the receiver stalls,
// s_tready stays low once that register is full and a finished query waits.
// Reset empties the store (vertex count zero) and drops any pending result;
// the vertex memory itself is not cleared.
`include "assert_macros.svh"

module polygon_signed_distance #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // opcode[1:0], coord_x, coord_y, zero pad
    input  logic [((2+2*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // status[1:0], inside_res, signed_distance[33:0], zero pad
    output logic [((3+psd_pkg::OUT_BITS+7)/8)*8-1:0]  m_tdata
);
    import psd_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int AB     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int DW     = CB + 1;
    localparam int S      = 2 * DW + 1;
    localparam int DB     = CB + 3;
    localparam int WNW    = CW + 1;
    localparam int OUT_W  = 3 + OUT_BITS;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int XW     = ((DB > OUT_BITS) ? DB : OUT_BITS) + 1;

    localparam logic [XW-1:0] LIM_POS = (XW'(1) << (OUT_BITS - 1)) - XW'(1);
    localparam logic [XW-1:0] LIM_NEG = XW'(1) << (OUT_BITS - 1);

    psd_state_t state_reg, state_next;

    // Vertex memory, {y, x} per entry
    logic [2*CB-1:0] vmem [MAX_VERTICES];
    logic [2*CB-1:0] rd_data_reg;
    logic [AB-1:0]   rd_addr;

    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          idx_reg;
    logic [2:0]             mstep_reg;
    logic                   go_reg;
    logic                   go_next;
    logic                   endc_reg;
    logic signed [CB-1:0]   px_reg, py_reg;
    logic signed [CB-1:0]   prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [DW-1:0]   ex_reg, ey_reg, qx_reg, qy_reg, vx_reg, vy_reg;
    logic signed [S-1:0]    t0_reg, cross_reg, dp_reg, ee_reg;
    logic [2*S-1:0]         val_reg;
    logic [DB-1:0]          best_reg;
    logic signed [WNW-1:0]  wn_reg;
    logic                   bnd_reg;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_data_reg;

    logic                   accept;
    logic                   out_free;
    logic                   start_run;
    logic                   load_out;
    logic                   has_room;
    logic                   enough;
    opcode_t                in_op;
    logic signed [CB-1:0]   in_x, in_y;
    logic signed [CB-1:0]   rd_x, rd_y;

    iter_req_t              ureq;
    logic [2*S-1:0]         u_opa;
    logic [S-1:0]           u_opb;
    logic                   u_done;
    logic [2*S-1:0]         u_res;

    logic signed [DW-1:0]   mul_a, mul_b;
    logic [DW-1:0]          mag_a, mag_b;
    logic                   mul_neg;
    logic signed [S-1:0]    prod_s;
    logic signed [S-1:0]    sum_next;
    logic [S-1:0]           cross_mag;
    logic                   perp;
    logic                   dp_ge_ee;
    logic                   dp_le0;
    logic                   on_seg;
    logic                   cross_pos, cross_neg, cross_zero;
    logic                   wn_up, wn_down, hit_bnd;
    logic                   last_edge;
    logic [DB-1:0]          root_d;

    logic [1:0]             o_status;
    logic                   o_inside;
    logic [OUT_BITS-1:0]    o_dist;
    logic [XW-1:0]          dext;
    logic [XW-1:0]          dsat;

    assign in_op = opcode_t'(s_tdata[1:0]);
    assign in_x  = s_tdata[2 +: CB];
    assign in_y  = s_tdata[2+CB +: CB];
    assign rd_x  = rd_data_reg[CB-1:0];
    assign rd_y  = rd_data_reg[2*CB-1:CB];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign has_room  = cnt_reg < CW'(MAX_VERTICES);
    assign enough    = cnt_reg >= CW'(3);
    assign start_run = accept && (in_op == OP_QUERY) && enough;
    assign load_out  = (accept && !start_run) || ((state_reg == ST_OUT) && out_free);
    assign last_edge = (idx_reg + CW'(1)) == cnt_reg;

    // Multiply operand pairs for each micro step
    always_comb begin
        unique case (mstep_reg)
            3'd0: begin mul_a = ex_reg; mul_b = qy_reg; end
            3'd1: begin mul_a = ey_reg; mul_b = qx_reg; end
            3'd2: begin mul_a = qx_reg; mul_b = ex_reg; end
            3'd3: begin mul_a = qy_reg; mul_b = ey_reg; end
            3'd4: begin mul_a = ex_reg; mul_b = ex_reg; end
            3'd5: begin mul_a = ey_reg; mul_b = ey_reg; end
            3'd6: begin
                mul_a = endc_reg ? vx_reg : qx_reg;
                mul_b = mul_a;
            end
            default: begin
                mul_a = endc_reg ? vy_reg : qy_reg;
                mul_b = mul_a;
            end
        endcase
    end

    assign mag_a   = mul_a[DW-1] ? DW'(-mul_a) : DW'(mul_a);
    assign mag_b   = mul_b[DW-1] ? DW'(-mul_b) : DW'(mul_b);
    assign mul_neg = mul_a[DW-1] ^ mul_b[DW-1];
    assign prod_s  = mul_neg ? -$signed(u_res[S-1:0]) : $signed(u_res[S-1:0]);
    assign sum_next = ((mstep_reg == 3'd1) ? (t0_reg - prod_s) : (t0_reg + prod_s));
    assign cross_mag = cross_reg[S-1] ? S'(-cross_reg) : S'(cross_reg);

    // Edge classification once the edge length is known (step five)
    assign dp_ge_ee   = dp_reg >= sum_next;
    assign dp_le0     = dp_reg[S-1] || (dp_reg == '0);
    assign perp       = !dp_ge_ee && !dp_le0;
    assign on_seg     = !dp_reg[S-1] && (dp_reg <= sum_next);
    assign cross_zero = (cross_reg == '0);
    assign cross_neg  = cross_reg[S-1];
    assign cross_pos  = !cross_neg && !cross_zero;

    // Winding contribution of the edge from prev to cur
    always_comb begin
        wn_up   = 1'b0;
        wn_down = 1'b0;
        hit_bnd = 1'b0;
        if (prev_y_reg <= py_reg) begin
            if (cur_y_reg >= py_reg) begin
                if (cross_pos && (cur_y_reg > py_reg)) begin
                    wn_up = 1'b1;
                end else if (cross_zero && on_seg) begin
                    hit_bnd = 1'b1;
                end
            end
        end else if (cur_y_reg <= py_reg) begin
            if (cross_neg) begin
                wn_down = 1'b1;
            end else if (cross_zero && on_seg) begin
                hit_bnd = 1'b1;
            end
        end
    end

    assign root_d = u_res[DB-1:0];

    // Sequencer: next state, unit requests, memory address
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        rd_addr    = idx_reg[AB-1:0];
        ureq.start = go_reg;
        ureq.op    = IT_MUL;
        u_opa      = (2*S)'(mag_a);
        u_opb      = S'(mag_b);
        go_next    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = out_free;
                if (start_run) begin
                    state_next = ST_RD_PREV;
                end
            end
            ST_RD_PREV: begin
                rd_addr    = AB'(cnt_reg - CW'(1));
                state_next = ST_LD_PREV;
            end
            ST_LD_PREV: state_next = ST_RD_CUR;
            ST_RD_CUR:  state_next = ST_LD_CUR;
            ST_LD_CUR: begin
                state_next = ST_MUL;
                go_next    = 1'b1;
            end
            ST_MUL: begin
                if (u_done) begin
                    go_next = 1'b1;
                    if (mstep_reg == 3'd7) begin
                        state_next = ST_ROOT;
                    end else if ((mstep_reg == 3'd5) && perp) begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                u_opa = (2*S)'(cross_mag);
                u_opb = cross_mag;
                if (u_done) begin
                    state_next = ST_DIV;
                    go_next    = 1'b1;
                end
            end
            ST_DIV: begin
                ureq.op = IT_DIV;
                u_opa   = val_reg;
                u_opb   = ee_reg;
                if (u_done) begin
                    state_next = ST_ROOT;
                    go_next    = 1'b1;
                end
            end
            ST_ROOT: begin
                ureq.op = IT_SQRT;
                u_opa   = val_reg;
                if (u_done) begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: state_next = last_edge ? ST_OUT : ST_RD_CUR;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            go_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
        end
    end

    // Vertex count: clear and append
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept && (in_op == OP_CLEAR)) begin
            cnt_reg <= '0;
        end else if (accept && (in_op == OP_APPEND) && has_room) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    // Vertex memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (accept && (in_op == OP_APPEND) && has_room) begin
            vmem[cnt_reg[AB-1:0]] <= {in_y, in_x};
        end
        rd_data_reg <= vmem[rd_addr];
    end

    // Query datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (start_run) begin
                    px_reg <= in_x;
                    py_reg <= in_y;
                end
            end
            ST_LD_PREV: begin
                prev_x_reg <= rd_x;
                prev_y_reg <= rd_y;
                idx_reg    <= '0;
                wn_reg     <= '0;
                bnd_reg    <= 1'b0;
            end
            ST_LD_CUR: begin
                cur_x_reg <= rd_x;
                cur_y_reg <= rd_y;
                ex_reg    <= DW'(rd_x) - DW'(prev_x_reg);
                ey_reg    <= DW'(rd_y) - DW'(prev_y_reg);
                qx_reg    <= DW'(px_reg) - DW'(prev_x_reg);
                qy_reg    <= DW'(py_reg) - DW'(prev_y_reg);
                vx_reg    <= DW'(px_reg) - DW'(rd_x);
                vy_reg    <= DW'(py_reg) - DW'(rd_y);
                mstep_reg <= 3'd0;
            end
            ST_MUL: begin
                if (u_done) begin
                    mstep_reg <= mstep_reg + 3'd1;
                    unique case (mstep_reg)
                        3'd1: cross_reg <= sum_next;
                        3'd3: dp_reg    <= sum_next;
                        3'd5: begin
                            ee_reg   <= sum_next;
                            endc_reg <= dp_ge_ee;
                            if (wn_up) begin
                                wn_reg <= wn_reg + WNW'(1);
                            end else if (wn_down) begin
                                wn_reg <= wn_reg - WNW'(1);
                            end
                            if (hit_bnd) begin
                                bnd_reg <= 1'b1;
                            end
                        end
                        3'd7: val_reg <= (2*S)'(sum_next);
                        default: t0_reg <= prod_s;
                    endcase
                end
            end
            ST_SQ, ST_DIV: begin
                if (u_done) begin
                    val_reg <= u_res;
                end
            end
            ST_ROOT: begin
                if (u_done && ((idx_reg == '0) || (root_d < best_reg))) begin
                    best_reg <= root_d;
                end
            end
            ST_NEXT: begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                idx_reg    <= idx_reg + CW'(1);
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // Result fields
    assign dext = XW'(best_reg);
    always_comb begin
        o_status = STAT_OK;
        o_inside = 1'b0;
        o_dist   = '0;
        dsat     = '0;
        if (state_reg == ST_OUT) begin
            o_inside = bnd_reg || (wn_reg != '0);
            if (o_inside) begin
                dsat   = (dext > LIM_POS) ? LIM_POS : dext;
                o_dist = dsat[OUT_BITS-1:0];
            end else begin
                dsat   = (dext > LIM_NEG) ? LIM_NEG : dext;
                o_dist = OUT_BITS'(-dsat);
            end
        end else if ((in_op == OP_APPEND) && !has_room) begin
            o_status = STAT_FULL;
        end else if (in_op == OP_QUERY) begin
            o_status = STAT_FEW;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= {o_dist, o_inside, o_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'(m_data_reg);

    psd_iter #(
        .S (S)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .opa     (u_opa),
        .opb     (u_opb),
        .done    (u_done),
        .result  (u_res)
    );

    // No request is taken while a query walks the edges
    `ASSERT_CLK(a_busy_no_accept, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_tready)
    // Vertex count never passes the store depth
    `ASSERT_NEVER(a_cnt_bound, aclk, aresetn, cnt_reg > CW'(MAX_VERTICES))
    // Edge walk stays within the stored vertices
    `ASSERT_CLK(a_idx_bound, aclk, aresetn, (state_reg == ST_MUL) |-> (idx_reg < cnt_reg))

endmodule
